// ----- hw/rtl/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// pva_pkg
// types, codes and sizes shared by the voice allocator files
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

	// number of voices kept by the allocator (1 to 8)
	localparam int unsigned VOICES  = 8;
	// fixed field widths of the items
	localparam int unsigned NOTE_W  = 8;
	localparam int unsigned PNOTE_W = 7;
	localparam int unsigned MASK_W  = 8;
	localparam int unsigned VFIELD_W = 3;
	localparam int unsigned VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;

	// command codes
	localparam logic CMD_NOTE_ON  = 1'b0;
	localparam logic CMD_NOTE_OFF = 1'b1;

	typedef enum logic [1:0] {
		ST_FREE      = 2'd0,
		ST_RELEASING = 2'd1,
		ST_HOLDING   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACT_TRIGGER = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_NOMATCH = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PNOTE_W-1:0] note;
	} voice_entry_t;

	typedef voice_entry_t [VOICES-1:0] voice_row_t;

	localparam int unsigned ROW_W = $bits(voice_row_t);

	// the whole voice table lives in one memory row
	localparam int unsigned STATE_DEPTH = 1;
	localparam logic        STATE_ROW   = 1'b0;

	typedef struct packed {
		logic                cmd;
		logic [NOTE_W-1:0]   note;
		logic [MASK_W-1:0]   mask;
	} alloc_req_t;

	typedef struct packed {
		voice_row_t          row;
		logic [VFIELD_W-1:0] voice;
		action_t             action;
		logic [PNOTE_W-1:0]  played_note;
	} alloc_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pva_if.sv -----
// ----------------------------------------------------------------------------
// pva_if
// handshake channels for note events and allocation results
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_req_if import pva_pkg::*; ;
	logic              valid;
	logic              ready;
	logic              command;
	logic [NOTE_W-1:0] note;
	logic [MASK_W-1:0] active_mask;

	modport source (output valid, command, note, active_mask, input ready);
	modport sink   (input valid, command, note, active_mask, output ready);
endinterface

interface pva_rsp_if import pva_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [VFIELD_W-1:0] voice;
	logic [1:0]          action;
	logic [PNOTE_W-1:0]  played_note;

	modport source (output valid, voice, action, played_note, input ready);
	modport sink   (input valid, voice, action, played_note, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pva_ram.sv -----
// ----------------------------------------------------------------------------
// pva_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pva_alloc.sv -----
// ----------------------------------------------------------------------------
// pva_alloc
// next voice table and result for one note event
// ----------------------------------------------------------------------------
`default_nettype none

module pva_alloc import pva_pkg::*; (
	input  wire alloc_req_t req,
	input  wire voice_row_t row,
	output alloc_res_t      res
);

	localparam int unsigned EXT_W = VOICES + MASK_W;

	logic [PNOTE_W-1:0]  pnote;
	logic [EXT_W-1:0]    mask_ext;
	voice_row_t          freed;
	logic                free_hit, rel_hit, hold_hit;
	logic [VIDX_W-1:0]   free_idx, rel_idx, hold_idx, pick;
	logic [VIDX_W+VFIELD_W-1:0] voice_ext;

	assign pnote    = req.note[NOTE_W-1] ? '0 : req.note[PNOTE_W-1:0];
	// voices past the mask width have no bit and count as inactive
	assign mask_ext = EXT_W'(req.mask);

	always_comb begin
		freed    = row;
		free_hit = 1'b0;
		rel_hit  = 1'b0;
		hold_hit = 1'b0;
		free_idx = '0;
		rel_idx  = '0;
		hold_idx = '0;
		for (int i = 0; i < VOICES; i++) begin
			if (!mask_ext[i]) begin
				freed[i].status = ST_FREE;
			end
		end
		// downward scan so the lowest index wins
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (freed[i].status == ST_FREE) begin
				free_hit = 1'b1;
				free_idx = VIDX_W'(i);
			end
			if (freed[i].status == ST_RELEASING) begin
				rel_hit = 1'b1;
				rel_idx = VIDX_W'(i);
			end
			if (row[i].status == ST_HOLDING && row[i].note == pnote) begin
				hold_hit = 1'b1;
				hold_idx = VIDX_W'(i);
			end
		end
	end

	always_comb begin
		pick            = '0;
		res.row         = row;
		res.action      = ACT_NOMATCH;
		res.played_note = pnote;
		case (req.cmd)
			CMD_NOTE_ON: begin
				if (free_hit) begin
					pick = free_idx;
				end else if (rel_hit) begin
					pick = rel_idx;
				end
				res.row              = freed;
				res.row[pick].status = ST_HOLDING;
				res.row[pick].note   = pnote;
				res.action           = ACT_TRIGGER;
			end
			CMD_NOTE_OFF: begin
				if (hold_hit) begin
					pick                 = hold_idx;
					res.row[pick].status = ST_RELEASING;
					res.action           = ACT_RELEASE;
				end
			end
			default: begin
				res.action = ACT_NOMATCH;
			end
		endcase
		voice_ext = (VIDX_W + VFIELD_W)'(pick);
		res.voice = voice_ext[VFIELD_W-1:0];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/polyphonic_voice_allocator.sv -----
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// note-on / note-off voice allocation with release stealing
// ----------------------------------------------------------------------------
// Each note event on req gives exactly one item on rsp. A note-on frees every
// voice whose bit in active_mask is clear, then triggers the lowest free voice,
// else the lowest releasing voice, else steals voice 0, and reports it as a
// trigger. A note-off releases the lowest holding voice playing that note, or
// reports no match with voice 0. Negative notes play as note 0. The voice
// table (status and note of every voice) is one row of a synchronous ram:
// an item is read in the cycle it is accepted, then updated and written back
// in S_EXEC once the result slot is free, and a new item is accepted only after
// that write-back; a result that is not taken holds the write-back and stalls
// the block. No clearing pass is needed after reset: until the first write the
// row reads as all voices free with note 0.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphonic_voice_allocator import pva_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	pva_req_if.sink  req,
	pva_rsp_if.source rsp
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t     state_q;
	logic       row_init_q;    // row has been written since reset
	logic       rsp_valid_q;
	alloc_req_t evt_q;         // event held while the row is read

	logic [ROW_W-1:0] rd_data;
	voice_row_t       cur_row;
	alloc_res_t       upd;
	logic             accept;
	logic             slot_free;
	logic             commit;

	logic [VFIELD_W-1:0] voice_q;
	logic [1:0]          action_q;
	logic [PNOTE_W-1:0]  played_note_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	// result slot may be reloaded when empty or being taken this cycle
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign commit    = (state_q == S_EXEC) && slot_free;

	// unwritten row reads as reset: every voice free, note 0
	assign cur_row = row_init_q ? voice_row_t'(rd_data) : '0;

	pva_ram #(
		.WIDTH (ROW_W),
		.DEPTH (STATE_DEPTH)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (STATE_ROW),
		.wr_data (ROW_W'(upd.row)),
		.rd_en   (accept),
		.rd_addr (STATE_ROW),
		.rd_data (rd_data)
	);

	pva_alloc u_alloc (
		.req (evt_q),
		.row (cur_row),
		.res (upd)
	);

	// event payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			evt_q.cmd  <= req.command;
			evt_q.note <= req.note;
			evt_q.mask <= req.active_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_init_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
			voice_q       <= '0;
			action_q      <= '0;
			played_note_q <= '0;
		end else begin
			// slot empties when taken and nothing new is loaded behind it
			if (rsp_valid_q && rsp.ready && !commit) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// write-back and result load happen together
					if (slot_free) begin
						row_init_q    <= 1'b1;
						rsp_valid_q   <= 1'b1;
						voice_q       <= upd.voice;
						action_q      <= upd.action;
						played_note_q <= upd.played_note;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.voice       = voice_q;
	assign rsp.action      = action_q;
	assign rsp.played_note = played_note_q;

endmodule

`default_nettype wire
